[sv/vng_pkg.sv]
// Shared types and constants for the vertex normal generator.
// No dependencies; every other file but vng_checker imports this package.
package vng_pkg;

   localparam int VERTS    = 1024;
   localparam int IDX_W    = 10;
   localparam int POS_W    = 24;
   localparam int SUM_W    = 24;
   localparam int NRM_W    = 16;
   localparam int CRS_W    = 51;
   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = 2;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TRI  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_TRI  = 2'd1,
      KIND_READ = 2'd2,
      KIND_NOP  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [IDX_W-1:0]          ia;
      logic [IDX_W-1:0]          ib;
      logic [IDX_W-1:0]          ic;
      logic signed [POS_W-1:0]   px;
      logic signed [POS_W-1:0]   py;
      logic signed [POS_W-1:0]   pz;
   } cmd_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]   nx;
      logic signed [NRM_W-1:0]   ny;
      logic signed [NRM_W-1:0]   nz;
      logic                      sat;
   } rsp_type;

   typedef struct packed {
      logic                      start;
      logic signed [CRS_W-1:0]   v0;
      logic signed [CRS_W-1:0]   v1;
      logic signed [CRS_W-1:0]   v2;
   } norm_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [NRM_W-1:0]   n0;
      logic signed [NRM_W-1:0]   n1;
      logic signed [NRM_W-1:0]   n2;
   } norm_rsp_type;

endpackage

[sv/vng_front.sv]
// Front end: accepts request items, classifies them and queues commands.
// Depends on vng_pkg.
module vng_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    opcode,
   input  logic [vng_pkg::IDX_W-1:0]     index_a,
   input  logic [vng_pkg::IDX_W-1:0]     index_b,
   input  logic [vng_pkg::IDX_W-1:0]     index_c,
   input  logic signed [vng_pkg::POS_W-1:0] pos_x,
   input  logic signed [vng_pkg::POS_W-1:0] pos_y,
   input  logic signed [vng_pkg::POS_W-1:0] pos_z,
   output vng_pkg::cmd_type              cmd,
   output logic                          cmd_valid,
   input  logic                          cmd_take
);
   import vng_pkg::*;

   localparam logic [IDX_W:0] VERTS_L = (IDX_W+1)'(VERTS);

   cmd_type             q_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CQ_PTR_W:0]   cnt_ff, cnt_in;
   kind_type            kind;
   logic                ok_a, ok_b, ok_c, do_push, do_pop;

   // classify: out-of-range indexes and the unused opcode turn the item into a no-op
   always_comb begin
      ok_a = {1'b0, index_a} < VERTS_L;
      ok_b = {1'b0, index_b} < VERTS_L;
      ok_c = {1'b0, index_c} < VERTS_L;
      unique case (opcode_type'(opcode))
         OP_LOAD: kind = ok_a ? KIND_LOAD : KIND_NOP;
         OP_TRI:  kind = (ok_a && ok_b && ok_c) ? KIND_TRI : KIND_NOP;
         OP_READ: kind = ok_a ? KIND_READ : KIND_NOP;
         default: kind = KIND_NOP;
      endcase
   end

   assign full      = (cnt_ff == (CQ_PTR_W+1)'(CQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (CQ_PTR_W+1)'(do_push) - (CQ_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= '{kind: kind, ia: index_a, ib: index_b, ic: index_c,
                          px: pos_x, py: pos_y, pz: pos_z};
      end
   end

endmodule

[sv/vng_norm.sv]
// Iterative normalizer: magnitude prescale, sum of squares, bit-serial
// square root and restoring division to a Q1.14 unit vector. Uses vng_pkg.
module vng_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  vng_pkg::norm_req_type req,
   output vng_pkg::norm_rsp_type rsp
);
   import vng_pkg::*;

   typedef enum logic [6:0] {
      N_IDLE  = 7'b0000001,
      N_SHIFT = 7'b0000010,
      N_SQ    = 7'b0000100,
      N_ROOT  = 7'b0001000,
      N_DSET  = 7'b0010000,
      N_DIV   = 7'b0100000,
      N_DONE  = 7'b1000000
   } nstate_type;

   nstate_type        st_ff;
   logic              neg_ff [3];
   logic [CRS_W-1:0]  m_ff [3];
   logic [4:0]        cnt_ff;
   logic [59:0]       prod_ff;
   logic [61:0]       acc_ff;
   logic [61:0]       rn_ff;
   logic [62:0]       rres_ff, rbit_ff;
   logic [30:0]       len_ff, rem_ff;
   logic [14:0]       qsh_ff;
   logic [1:0]        comp_ff;
   logic [14:0]       q_ff [3];

   logic [62:0]       rsum, rres_in;
   logic              rge;
   logic [44:0]       num;
   logic [31:0]       dt;
   logic              dge;
   logic [CRS_W-1:0]  big;
   logic [29:0]       sq_op;
   logic signed [CRS_W-1:0] vin [3];

   always_comb begin
      vin[0] = req.v0;
      vin[1] = req.v1;
      vin[2] = req.v2;
      big    = m_ff[0] | m_ff[1] | m_ff[2];
      case (cnt_ff[1:0])
         2'd0:    sq_op = m_ff[0][29:0];
         2'd1:    sq_op = m_ff[1][29:0];
         default: sq_op = m_ff[2][29:0];
      endcase
      // one root step
      rsum    = rres_ff + rbit_ff;
      rge     = {1'b0, rn_ff} >= rsum;
      rres_in = rge ? (rres_ff >> 1) + rbit_ff : rres_ff >> 1;
      // rounded numerator and one division step
      num     = {1'b0, m_ff[comp_ff][29:0], 14'b0} + 45'(len_ff[30:1]);
      dt      = {rem_ff, qsh_ff[14]};
      dge     = dt >= {1'b0, len_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= N_IDLE;
      end else begin
         unique case (st_ff)
            N_IDLE:  if (req.start) st_ff <= N_SHIFT;
            N_SHIFT: if ((big >> 30) == '0) st_ff <= N_SQ;
            N_SQ:    if (cnt_ff == 5'd3) st_ff <= N_ROOT;
            N_ROOT:  if (cnt_ff == 5'd31) st_ff <= N_DSET;
            N_DSET:  st_ff <= (len_ff == '0) ? N_DONE : N_DIV;
            N_DIV:   if (cnt_ff == 5'd14) st_ff <= (comp_ff == 2'd2) ? N_DONE : N_DSET;
            N_DONE:  st_ff <= N_IDLE;
            default: st_ff <= N_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (st_ff)
         N_IDLE: begin
            for (int k = 0; k < 3; k++) begin
               neg_ff[k] <= vin[k] < 0;
               m_ff[k]   <= (vin[k] < 0) ? CRS_W'(-vin[k]) : CRS_W'(vin[k]);
            end
            cnt_ff <= '0;
         end
         N_SHIFT: begin
            if ((big >> 30) != '0) begin
               for (int k = 0; k < 3; k++) m_ff[k] <= m_ff[k] >> 1;
            end
            cnt_ff <= '0;
            acc_ff <= '0;
         end
         N_SQ: begin
            prod_ff <= sq_op * sq_op;
            if (cnt_ff == 5'd1 || cnt_ff == 5'd2) acc_ff <= acc_ff + 62'(prod_ff);
            if (cnt_ff == 5'd3) begin
               rn_ff   <= acc_ff + 62'(prod_ff);
               rres_ff <= '0;
               rbit_ff <= 63'(1) << 62;
               cnt_ff  <= '0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         N_ROOT: begin
            if (rge) rn_ff <= rn_ff - rsum[61:0];
            rres_ff <= rres_in;
            rbit_ff <= rbit_ff >> 2;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               len_ff  <= rres_in[30:0];
               comp_ff <= '0;
            end
         end
         N_DSET: begin
            if (len_ff == '0) begin
               for (int k = 0; k < 3; k++) q_ff[k] <= '0;
            end
            rem_ff <= {1'b0, num[44:15]};
            qsh_ff <= num[14:0];
            cnt_ff <= '0;
         end
         N_DIV: begin
            rem_ff <= dge ? 31'(dt - {1'b0, len_ff}) : dt[30:0];
            qsh_ff <= {qsh_ff[13:0], dge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd14) begin
               q_ff[comp_ff] <= {qsh_ff[13:0], dge};
               comp_ff       <= comp_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // signed result
   always_comb begin
      rsp.done = (st_ff == N_DONE);
      rsp.n0   = neg_ff[0] ? -NRM_W'(q_ff[0]) : NRM_W'(q_ff[0]);
      rsp.n1   = neg_ff[1] ? -NRM_W'(q_ff[1]) : NRM_W'(q_ff[1]);
      rsp.n2   = neg_ff[2] ? -NRM_W'(q_ff[2]) : NRM_W'(q_ff[2]);
   end

endmodule

[sv/vng_core.sv]
// Back end: position and sum memories, cross product, normal accumulation
// and result build. Depends on vng_pkg and vng_norm.
module vng_core (
   input  logic              clock,
   input  logic              reset,
   input  vng_pkg::cmd_type  cmd,
   input  logic              cmd_valid,
   output logic              cmd_take,
   output vng_pkg::rsp_type  res,
   output logic              res_push,
   input  logic              res_full
);
   import vng_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_PA     = 11'b00000000010,
      S_PB     = 11'b00000000100,
      S_PC     = 11'b00000001000,
      S_MUL    = 11'b00000010000,
      S_NSTART = 11'b00000100000,
      S_NWAIT  = 11'b00001000000,
      S_SUMRD  = 11'b00010000000,
      S_SUMWR  = 11'b00100000000,
      S_SR     = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   function automatic logic [SUM_W:0] sat_add(logic signed [SUM_W-1:0] s,
                                              logic signed [NRM_W-1:0] d);
      logic signed [SUM_W:0] r;
      r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
      if (r > 25'sd8388607)       return {1'b1, 24'h7FFFFF};
      else if (r < -25'sd8388608) return {1'b1, 24'h800000};
      else                        return {1'b0, r[SUM_W-1:0]};
   endfunction

   state_type               st_ff;
   cmd_type                 cmd_ff;
   logic signed [POS_W-1:0] a_ff [3];
   logic signed [POS_W:0]   e1_ff [3], e2_ff [3];
   logic signed [CRS_W-1:0] c_ff [3];
   logic signed [2*POS_W+1:0] prod_ff;
   logic [2:0]              cnt_ff;
   logic signed [NRM_W-1:0] f_ff [3];
   logic                    sat_ff;
   logic [1:0]              corner_ff;
   rsp_type                 res_ff;

   logic [3*POS_W-1:0]      pos_mem [VERTS];
   logic [3*SUM_W-1:0]      sum_mem [VERTS];
   logic [3*POS_W-1:0]      pos_q;
   logic [3*SUM_W-1:0]      sum_q;
   logic [IDX_W-1:0]        pos_ra, sum_ra, sum_wa, corner_idx;
   logic                    pos_we, sum_we;
   logic [3*SUM_W-1:0]      sum_wd;
   logic signed [POS_W-1:0] p [3];
   logic signed [POS_W:0]   mul_a, mul_b;
   logic [2:0]              acc_j;
   logic [SUM_W:0]          sx, sy, sz;
   norm_req_type            nreq;
   norm_rsp_type            nrsp;

   vng_norm u_norm (.clock(clock), .reset(reset), .req(nreq), .rsp(nrsp));

   assign cmd_take = (st_ff == S_IDLE) && cmd_valid;
   assign res_push = (st_ff == S_DONE) && !res_full;
   assign res      = res_ff;

   // memory addressing
   always_comb begin
      case (corner_ff)
         2'd0:    corner_idx = cmd_ff.ia;
         2'd1:    corner_idx = cmd_ff.ib;
         default: corner_idx = cmd_ff.ic;
      endcase
      case (st_ff)
         S_PA:    pos_ra = cmd_ff.ib;
         S_PB:    pos_ra = cmd_ff.ic;
         default: pos_ra = cmd.ia;
      endcase
      sum_ra = (st_ff == S_IDLE) ? cmd.ia : corner_idx;
      pos_we = cmd_take && (cmd.kind == KIND_LOAD);
      sx = sat_add(sum_q[3*SUM_W-1:2*SUM_W], f_ff[0]);
      sy = sat_add(sum_q[2*SUM_W-1:SUM_W],   f_ff[1]);
      sz = sat_add(sum_q[SUM_W-1:0],         f_ff[2]);
      if (st_ff == S_SUMWR) begin
         sum_we = 1'b1;
         sum_wa = corner_idx;
         sum_wd = {sx[SUM_W-1:0], sy[SUM_W-1:0], sz[SUM_W-1:0]};
      end else begin
         sum_we = pos_we;
         sum_wa = cmd.ia;
         sum_wd = '0;
      end
      p[0] = pos_q[3*POS_W-1:2*POS_W];
      p[1] = pos_q[2*POS_W-1:POS_W];
      p[2] = pos_q[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[cmd.ia] <= {cmd.px, cmd.py, cmd.pz};
      pos_q <= pos_mem[pos_ra];
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      sum_q <= sum_mem[sum_ra];
   end

   // cross product operand select
   always_comb begin
      case (cnt_ff)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
      acc_j     = cnt_ff - 3'd1;
      nreq.start = (st_ff == S_NSTART);
      nreq.v0    = c_ff[0];
      nreq.v1    = c_ff[1];
      nreq.v2    = c_ff[2];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  unique case (cmd.kind)
                     KIND_TRI:  st_ff <= S_PA;
                     KIND_READ: st_ff <= S_SR;
                     default:   st_ff <= S_DONE;
                  endcase
               end
            end
            S_PA:     st_ff <= S_PB;
            S_PB:     st_ff <= S_PC;
            S_PC:     st_ff <= S_MUL;
            S_MUL:    if (cnt_ff == 3'd6) st_ff <= S_NSTART;
            S_NSTART: st_ff <= S_NWAIT;
            S_NWAIT:  if (nrsp.done) st_ff <= (cmd_ff.kind == KIND_TRI) ? S_SUMRD : S_DONE;
            S_SUMRD:  st_ff <= S_SUMWR;
            S_SUMWR:  st_ff <= (corner_ff == 2'd2) ? S_DONE : S_SUMRD;
            S_SR:     st_ff <= S_NSTART;
            S_DONE:   if (!res_full) st_ff <= S_IDLE;
            default:  st_ff <= S_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (st_ff)
         S_IDLE: begin
            cmd_ff    <= cmd;
            sat_ff    <= 1'b0;
            corner_ff <= '0;
            cnt_ff    <= '0;
            res_ff    <= '0;
         end
         S_PA: for (int k = 0; k < 3; k++) a_ff[k] <= p[k];
         S_PB: for (int k = 0; k < 3; k++) e1_ff[k] <= (POS_W+1)'(p[k]) - (POS_W+1)'(a_ff[k]);
         S_PC: for (int k = 0; k < 3; k++) e2_ff[k] <= (POS_W+1)'(p[k]) - (POS_W+1)'(a_ff[k]);
         S_MUL: begin
            prod_ff <= mul_a * mul_b;
            if (cnt_ff != 3'd0) begin
               if (!acc_j[0]) c_ff[acc_j[2:1]] <= CRS_W'(prod_ff);
               else           c_ff[acc_j[2:1]] <= c_ff[acc_j[2:1]] - CRS_W'(prod_ff);
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
         S_SR: begin
            c_ff[0] <= CRS_W'($signed(sum_q[3*SUM_W-1:2*SUM_W]));
            c_ff[1] <= CRS_W'($signed(sum_q[2*SUM_W-1:SUM_W]));
            c_ff[2] <= CRS_W'($signed(sum_q[SUM_W-1:0]));
         end
         S_NWAIT: begin
            if (nrsp.done) begin
               f_ff[0] <= nrsp.n0;
               f_ff[1] <= nrsp.n1;
               f_ff[2] <= nrsp.n2;
               if (cmd_ff.kind != KIND_TRI) begin
                  res_ff <= '{nx: nrsp.n0, ny: nrsp.n1, nz: nrsp.n2, sat: 1'b0};
               end
            end
         end
         S_SUMWR: begin
            sat_ff    <= sat_ff | sx[SUM_W] | sy[SUM_W] | sz[SUM_W];
            corner_ff <= corner_ff + 2'd1;
            if (corner_ff == 2'd2) begin
               res_ff <= '{nx: '0, ny: '0, nz: '0,
                           sat: sat_ff | sx[SUM_W] | sy[SUM_W] | sz[SUM_W]};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[sv/vertex_normal_generator.sv]
// Vertex normal generator: queue-style request and response ports, with the
// front end, processing core and a two-entry response queue. Uses vng_pkg.
//
// Items are processed one at a time by the core while the front end keeps
// accepting up to four queued requests. A load or an unused opcode goes
// straight to the done state. A normal read normalizes the vertex sum and a
// triangle normalizes its cross product; the divisions are skipped when the
// sum is zero or the triangle is degenerate. The normalizer runs up to 21
// prescale shifts, a 32-step bit-serial square root and three 15-step
// restoring divisions. A triangle adds three position reads, six serial
// cross-product multiplies and three read-modify-writes of the sum memory.
// A full response queue holds the core until there is room. Memories have no
// reset; reading a vertex that was never loaded returns undefined data.
module vertex_normal_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [1:0]                       req_opcode,
   input  logic [vng_pkg::IDX_W-1:0]        req_index_a,
   input  logic [vng_pkg::IDX_W-1:0]        req_index_b,
   input  logic [vng_pkg::IDX_W-1:0]        req_index_c,
   input  logic signed [vng_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [vng_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [vng_pkg::POS_W-1:0] req_pos_z,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic signed [vng_pkg::NRM_W-1:0] rsp_normal_x,
   output logic signed [vng_pkg::NRM_W-1:0] rsp_normal_y,
   output logic signed [vng_pkg::NRM_W-1:0] rsp_normal_z,
   output logic                             rsp_saturated
);
   import vng_pkg::*;

   cmd_type  cmd;
   logic     cmd_valid, cmd_take;
   rsp_type  res;
   logic     res_push, res_full;

   rsp_type  oq_ff [2];
   logic     owr_ff, ord_ff;
   logic [1:0] ocnt_ff;
   logic     do_pop;

   vng_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .opcode(req_opcode), .index_a(req_index_a), .index_b(req_index_b),
      .index_c(req_index_c), .pos_x(req_pos_x), .pos_y(req_pos_y),
      .pos_z(req_pos_z), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
   );

   vng_core u_core (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_take(cmd_take), .res(res), .res_push(res_push), .res_full(res_full)
   );

   // response queue
   assign res_full  = (ocnt_ff == 2'd2);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp_normal_x  = oq_ff[ord_ff].nx;
   assign rsp_normal_y  = oq_ff[ord_ff].ny;
   assign rsp_normal_z  = oq_ff[ord_ff].nz;
   assign rsp_saturated = oq_ff[ord_ff].sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= '0;
      end else begin
         if (res_push) owr_ff <= !owr_ff;
         if (do_pop)   ord_ff <= !ord_ff;
         ocnt_ff <= ocnt_ff + 2'(res_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) oq_ff[owr_ff] <= res;
   end

endmodule

[sv/vng_checker.sv]
// Port-level checks for the vertex normal generator, bound to the top level.
// Depends on vertex_normal_generator's port list only.
module vng_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic signed [15:0] rsp_normal_z
);

   // queues come up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting item holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z))
      else $error("waiting item changed");

   // unit normal components stay within Q1.14 one
   a_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_normal_x >= -16'sd16384 && rsp_normal_x <= 16'sd16384
         && rsp_normal_y >= -16'sd16384 && rsp_normal_y <= 16'sd16384
         && rsp_normal_z >= -16'sd16384 && rsp_normal_z <= 16'sd16384)
      else $error("normal out of range");

   // the response queue is still empty when reset falls
   a_no_early: assert property (@(posedge clock) $fell(reset) |-> rsp_empty)
      else $error("result appeared right after reset");

endmodule

bind vertex_normal_generator vng_checker u_vng_checker (
   .clock(clock), .reset(reset), .req_full(req_full), .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop), .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
   .rsp_normal_z(rsp_normal_z)
);
